// ----- rtl/core/supd_pkg.sv -----
package supd_pkg;

  localparam int unsigned SampleCount = 32;
  localparam int unsigned IdxW        = $clog2(SampleCount);

  localparam logic [6:0] PosLast  = 7'd125;
  localparam logic [6:0] PosIdle  = 7'd126;

  localparam logic [7:0] FastMark   = 8'h80;
  localparam logic [7:0] SumMask    = 8'hAA;
  localparam logic [7:0] CheckOn    = 8'hBB;
  localparam logic [7:0] SlowCmdOk  = 8'h33;
  localparam logic [7:0] UploadCmd  = 8'h33;
  localparam logic [15:0] SignFlip  = 16'h8000;

  typedef enum logic [1:0] {
    RES_NOT_UPLOAD = 2'd0,
    RES_CSUM_FAIL  = 2'd1,
    RES_BAD_CMD    = 2'd2,
    RES_VALID      = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    CS_RECV,
    CS_STATUS,
    CS_FETCH,
    CS_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic take_byte;
    logic inc_idx;
  } supd_cmd_t;

  typedef struct packed {
    logic last_byte;
    logic samples;
    logic last_idx;
  } supd_stat_t;

endpackage

// ----- rtl/core/supd_ctrl.sv -----
module supd_ctrl
  import supd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_ready_i,
  input  supd_stat_t stat_i,
  output supd_cmd_t  cmd_o,
  output logic       in_ready_o,
  output logic       out_valid_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_RECV: begin
        if (in_valid_i && stat_i.last_byte) begin
          state_d = stat_i.samples ? CS_FETCH : CS_STATUS;
        end
      end
      CS_STATUS: begin
        if (out_ready_i) begin
          state_d = CS_RECV;
        end
      end
      CS_FETCH: state_d = CS_EMIT;
      CS_EMIT: begin
        if (out_ready_i) begin
          state_d = stat_i.last_idx ? CS_RECV : CS_FETCH;
        end
      end
      default: state_d = CS_RECV;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cmd_o.take_byte   = 1'b0;
    cmd_o.inc_idx     = 1'b0;
    case (state_q)
      CS_RECV: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_valid_i;
      end
      CS_STATUS: out_valid_o = 1'b1;
      CS_FETCH:  out_valid_o = 1'b0;
      CS_EMIT: begin
        out_valid_o   = 1'b1;
        cmd_o.inc_idx = out_ready_i;
      end
      default: out_valid_o = 1'b0;
    endcase
  end

endmodule

// ----- rtl/core/supd_dp.sv -----
module supd_dp
  import supd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  supd_cmd_t          cmd_i,
  output supd_stat_t         stat_o,
  input  logic [7:0]         data_byte_i,
  input  logic               packet_start_i,
  input  logic [7:0]         command_code_i,
  output logic [1:0]         status_o,
  output logic               fast_mode_o,
  output logic [15:0]        segment_addr_o,
  output logic signed [15:0] sample_o,
  output logic [4:0]         sample_index_o,
  output logic               last_o
);

  logic [6:0]      pos_q, pos_d, p;
  logic [7:0]      cmd_q, cmd_d;
  logic            fast_q, fast_d;
  logic [15:0]     seg_q, seg_d;
  logic [7:0]      dsum_q, dsum_d;
  logic [7:0]      ssum_q, ssum_d;
  logic [7:0]      cen_q, cen_d;
  logic            cok_q, cok_d;
  logic [15:0]     coll_q, coll_d;
  logic [7:0]      hold_q, hold_d;
  res_e            res_q, res_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic            pend_q, pend_d;
  logic            pend_grp_q, pend_grp_d;
  logic [15:0]     pend_data_q, pend_data_d;

  logic [15:0]     mem [SampleCount];
  logic [15:0]     rd_data_q;

  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [15:0]     wr_data;

  logic [6:0]      off_fast, off_slow;
  logic [4:0]      word_num, grp_pos;
  logic            grp;
  logic [15:0]     word, coll_base;
  logic [7:0]      sum_basic, sum_adv;
  logic            match, pass;
  logic            byte_wr;
  logic [IdxW-1:0] byte_addr;
  logic [15:0]     byte_data;
  res_e            verdict;

  assign p         = packet_start_i ? 7'd0 : pos_q;
  assign word      = {hold_q, data_byte_i};
  assign off_fast  = p - 7'd5;
  assign off_slow  = p - 7'd51;
  assign word_num  = off_fast[5:1];
  assign grp       = (word_num >= 5'd15);
  assign grp_pos   = grp ? (word_num - 5'd15) : word_num;
  assign coll_base = (grp_pos == 5'd0) ? 16'd0 : coll_q;

  assign sum_basic = dsum_q ^ SumMask;
  assign sum_adv   = (dsum_q + ssum_q) ^ SumMask;
  assign match     = (sum_basic == data_byte_i) || (sum_adv == data_byte_i);
  assign pass      = (fast_q || (cen_q == CheckOn)) ? match : 1'b1;

  always_comb begin
    if (cmd_q != UploadCmd) begin
      verdict = RES_NOT_UPLOAD;
    end else if (!pass) begin
      verdict = RES_CSUM_FAIL;
    end else if (!fast_q && !cok_q) begin
      verdict = RES_BAD_CMD;
    end else begin
      verdict = RES_VALID;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    cmd_d       = cmd_q;
    fast_d      = fast_q;
    seg_d       = seg_q;
    dsum_d      = dsum_q;
    ssum_d      = ssum_q;
    cen_d       = cen_q;
    cok_d       = cok_q;
    coll_d      = coll_q;
    hold_d      = hold_q;
    res_d       = res_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_grp_d  = pend_grp_q;
    pend_data_d = pend_data_q;
    byte_wr     = 1'b0;
    byte_addr   = '0;
    byte_data   = '0;

    if (cmd_i.inc_idx) begin
      idx_d = idx_q + 1'b1;
    end

    if (cmd_i.take_byte) begin
      if (p > PosLast) begin
        pos_d = PosIdle;
      end else begin
        pos_d = p + 7'd1;
        if (p == 7'd0) begin
          cmd_d  = command_code_i;
          fast_d = 1'b0;
          seg_d  = '0;
          dsum_d = '0;
          ssum_d = '0;
          cen_d  = '0;
          cok_d  = 1'b0;
          coll_d = '0;
          hold_d = '0;
        end
        if (p == 7'd2) begin
          fast_d = (data_byte_i == FastMark);
        end
        if (p inside {[7'd3:7'd6]}) begin
          ssum_d = ssum_q + data_byte_i;
        end
        if (p == 7'd45) begin
          cok_d = (data_byte_i == SlowCmdOk);
        end
        if (p == 7'd49) begin
          cen_d = data_byte_i;
        end

        if (fast_q) begin
          if (p == 7'd3) begin
            seg_d[15:8] = data_byte_i;
          end
          if (p == 7'd4) begin
            seg_d[7:0] = data_byte_i;
          end
          if (p inside {[7'd5:7'd124]}) begin
            dsum_d = dsum_q + data_byte_i;
          end
          if (p inside {[7'd5:7'd64]}) begin
            if (off_fast[0]) begin
              coll_d    = {word[0], coll_base[15:1]};
              byte_wr   = 1'b1;
              byte_addr = {grp, 4'(grp_pos[3:0] + 4'd1)};
              byte_data = {~word[15], word[14:1], word[1]};
              if (grp_pos == 5'd14) begin
                pend_d      = 1'b1;
                pend_grp_d  = grp;
                pend_data_d = {word[0], coll_base[15:1]} ^ SignFlip;
              end
            end else begin
              hold_d = data_byte_i;
            end
          end
        end else if (p != 7'd0) begin
          if (p == 7'd47) begin
            seg_d[15:8] = data_byte_i;
          end
          if (p == 7'd48) begin
            seg_d[7:0] = data_byte_i;
          end
          if (p inside {[7'd51:7'd114]}) begin
            dsum_d = dsum_q + data_byte_i;
            if (off_slow[0]) begin
              byte_wr   = 1'b1;
              byte_addr = off_slow[5:1];
              byte_data = word;
            end else begin
              hold_d = data_byte_i;
            end
          end
        end

        if (p == PosLast) begin
          res_d = verdict;
          idx_d = '0;
        end
      end
    end
  end

  // group head sample lands in the cycle after its last word; never collides
  assign wr_en   = byte_wr || pend_q;
  assign wr_addr = byte_wr ? byte_addr : {pend_grp_q, 4'd0};
  assign wr_data = byte_wr ? byte_data : pend_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      cmd_q      <= '0;
      fast_q     <= 1'b0;
      seg_q      <= '0;
      dsum_q     <= '0;
      ssum_q     <= '0;
      cen_q      <= '0;
      cok_q      <= 1'b0;
      coll_q     <= '0;
      hold_q     <= '0;
      res_q      <= RES_NOT_UPLOAD;
      idx_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      cmd_q      <= cmd_d;
      fast_q     <= fast_d;
      seg_q      <= seg_d;
      dsum_q     <= dsum_d;
      ssum_q     <= ssum_d;
      cen_q      <= cen_d;
      cok_q      <= cok_d;
      coll_q     <= coll_d;
      hold_q     <= hold_d;
      res_q      <= res_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_grp_q  <= pend_grp_d;
    pend_data_q <= pend_data_d;
  end

  assign stat_o.last_byte = (p == PosLast);
  assign stat_o.samples   = (verdict == RES_VALID);
  assign stat_o.last_idx  = (idx_q == IdxW'(SampleCount - 1));

  assign status_o       = res_q;
  assign fast_mode_o    = ((res_q == RES_CSUM_FAIL) || (res_q == RES_VALID)) ? fast_q : 1'b0;
  assign segment_addr_o = (res_q == RES_VALID) ? seg_q : 16'd0;
  assign sample_o       = (res_q == RES_VALID) ? $signed(rd_data_q) : 16'sd0;
  assign sample_index_o = (res_q == RES_VALID) ? 5'(idx_q) : 5'd0;
  assign last_o         = (res_q == RES_VALID) ? stat_o.last_idx : 1'b1;

endmodule

// ----- rtl/core/sample_upload_packet_decoder.sv -----
// Upload packet decoder: takes a 126-byte upload packet one byte per cycle
// (packet_start_i marks byte 0) and, after byte 125, emits either one status
// word or, for a valid packet, 32 sample words in index order with last_o on
// the final one. Bytes are taken at one per cycle; while results go out the
// input stalls. A status result is presented in CS_STATUS; each sample is
// read in CS_FETCH (registered read of the 32-entry sample memory), then
// output in CS_EMIT, so a valid packet holds the input off until its last
// sample is out. Bytes past byte 125 without a new packet_start_i are dropped.
module sample_upload_packet_decoder
  import supd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               packet_start_i,
  input  logic [7:0]         command_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               fast_mode_o,
  output logic [15:0]        segment_addr_o,
  output logic signed [15:0] sample_o,
  output logic [4:0]         sample_index_o,
  output logic               last_o
);

  supd_cmd_t  cmd;
  supd_stat_t stat;

  supd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  supd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .command_code_i (command_code_i),
    .status_o       (status_o),
    .fast_mode_o    (fast_mode_o),
    .segment_addr_o (segment_addr_o),
    .sample_o       (sample_o),
    .sample_index_o (sample_index_o),
    .last_o         (last_o)
  );

endmodule
